/* sv/rapc_pkg.sv */
// Shared types and constants of the read access pattern classifier.
package rapc_pkg;

    localparam int LineOffsetBitsDefault = 6;
    localparam int CountWidthDefault     = 48;
    localparam int AddrWidth             = 64;
    localparam int TotalWidth            = 48;

    typedef enum logic [2:0] {
        ACC_WRITE   = 3'd0,
        ACC_HIT     = 3'd1,
        ACC_STRIDED = 3'd2,
        ACC_CHASING = 3'd3,
        ACC_RANDOM  = 3'd4
    } t_access_class;

    typedef struct packed {
        logic                 mode;
        logic [AddrWidth-1:0] address;
        logic                 llc_hit;
        logic [AddrWidth-1:0] loaded_value;
    } t_in_word;

    typedef struct packed {
        t_access_class         access_class;
        logic [TotalWidth-1:0] reads_total;
        logic [TotalWidth-1:0] writes_total;
        logic [TotalWidth-1:0] hits_total;
        logic [TotalWidth-1:0] strided_total;
        logic [TotalWidth-1:0] chasing_total;
        logic [TotalWidth-1:0] random_total;
    } t_out_word;

endpackage

/* sv/rapc_stream_if.sv */
// Valid/ready stream interface that carries one word per handshake.
interface rapc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rapc_sat_counter.sv */
// Saturating event counter with synchronous clear.
module rapc_sat_counter #(
    parameter int WIDTH = rapc_pkg::CountWidthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_inc,
    output logic [WIDTH-1:0] o_count
);
    import rapc_pkg::*;

    logic [WIDTH-1:0] r_count;
    logic [WIDTH-1:0] n_count;

    // hold at all ones once reached
    always_comb begin
        n_count = r_count;
        if (i_inc && (r_count != {WIDTH{1'b1}})) begin
            n_count = r_count + WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
endmodule

/* sv/read_access_pattern_classifier_core.sv */
// Top level of the read access pattern classifier.
// Data path: an accepted word lands in the input register, is classified from there
//   into the result register and is offered on o_out while that register holds it.
// Throughput: one word per cycle while o_out is not stalled; while a result waits,
//   the input side still takes a word if the input register is empty or moves on.
// Reset (synchronous, active low): clears both valid flags, the line, stride and
//   word history and all six counters.
module read_access_pattern_classifier_core #(
    parameter int LINE_OFFSET_BITS = rapc_pkg::LineOffsetBitsDefault,
    parameter int COUNT_WIDTH      = rapc_pkg::CountWidthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rapc_stream_if.sink   i_in,
    rapc_stream_if.source o_out
);
    import rapc_pkg::*;

    // Byte offset within a cache line is cleared to form the line address.
    localparam logic [AddrWidth-1:0] LineMask =
        ~((AddrWidth'(1) << LINE_OFFSET_BITS) - AddrWidth'(1));

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic     r_s1_valid;
    t_in_word r_s1_word;
    logic     r_out_valid;
    logic     s1_advance;
    logic     in_take;

    // Advance the input register whenever the result register is empty or
    // is being drained at this edge.
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_advance;
    assign in_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Payload needs no reset: it is qualified by r_s1_valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word <= i_in.data;
        end
    end

    // ------------------------------------------------------------------
    // Classification against the miss history
    // ------------------------------------------------------------------
    logic [AddrWidth-1:0] r_prev_line;
    logic [AddrWidth-1:0] r_stride;
    logic [AddrWidth-1:0] r_prev_word;

    logic [AddrWidth-1:0] cur_line;
    logic                 stride_match;
    logic                 chase_match;
    logic                 is_miss;
    t_access_class        cur_class;

    assign cur_line     = r_s1_word.address & LineMask;
    // Expected line wraps modulo 2^64, as does the relearned stride below.
    assign stride_match = ((r_prev_line + r_stride) == cur_line);
    assign chase_match  = (r_s1_word.address == r_prev_word);
    assign is_miss      = !r_s1_word.mode && !r_s1_word.llc_hit;

    always_comb begin
        if (r_s1_word.mode) begin
            cur_class = ACC_WRITE;
        end else if (r_s1_word.llc_hit) begin
            cur_class = ACC_HIT;
        end else if (stride_match) begin
            cur_class = ACC_STRIDED;
        end else if (chase_match) begin
            cur_class = ACC_CHASING;
        end else begin
            cur_class = ACC_RANDOM;
        end
    end

    // History moves only on a read miss; writes and cache hits leave it alone.
    // Relearn the stride only when the expected line was not met.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_line <= '0;
            r_stride    <= '0;
            r_prev_word <= '0;
        end else if (s1_advance && is_miss) begin
            r_prev_line <= cur_line;
            r_prev_word <= r_s1_word.loaded_value;
            if (!stride_match) begin
                r_stride <= cur_line - r_prev_line;
            end
        end
    end

    // ------------------------------------------------------------------
    // Counters: they step together with the result register, so their
    // current values are always the totals that belong to the held result.
    // ------------------------------------------------------------------
    logic                   inc_read;
    logic                   inc_write;
    logic                   inc_hit;
    logic                   inc_strided;
    logic                   inc_chasing;
    logic                   inc_random;
    logic [COUNT_WIDTH-1:0] cnt_read;
    logic [COUNT_WIDTH-1:0] cnt_write;
    logic [COUNT_WIDTH-1:0] cnt_hit;
    logic [COUNT_WIDTH-1:0] cnt_strided;
    logic [COUNT_WIDTH-1:0] cnt_chasing;
    logic [COUNT_WIDTH-1:0] cnt_random;

    assign inc_read    = s1_advance && !r_s1_word.mode;
    assign inc_write   = s1_advance && (cur_class == ACC_WRITE);
    assign inc_hit     = s1_advance && (cur_class == ACC_HIT);
    assign inc_strided = s1_advance && (cur_class == ACC_STRIDED);
    assign inc_chasing = s1_advance && (cur_class == ACC_CHASING);
    assign inc_random  = s1_advance && (cur_class == ACC_RANDOM);

    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_read (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_read), .o_count(cnt_read)
    );
    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_write (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_write), .o_count(cnt_write)
    );
    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_hit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_hit), .o_count(cnt_hit)
    );
    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_strided (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_strided), .o_count(cnt_strided)
    );
    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_chasing (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_chasing), .o_count(cnt_chasing)
    );
    rapc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_cnt_random (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc_random), .o_count(cnt_random)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    t_access_class r_out_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_class <= cur_class;
        end
    end

    // Totals leave as 48-bit fields whatever the counter width.
    assign o_out.valid              = r_out_valid;
    assign o_out.data.access_class  = r_out_class;
    assign o_out.data.reads_total   = TotalWidth'(cnt_read);
    assign o_out.data.writes_total  = TotalWidth'(cnt_write);
    assign o_out.data.hits_total    = TotalWidth'(cnt_hit);
    assign o_out.data.strided_total = TotalWidth'(cnt_strided);
    assign o_out.data.chasing_total = TotalWidth'(cnt_chasing);
    assign o_out.data.random_total  = TotalWidth'(cnt_random);
endmodule

/* sv/rapc_checker.sv */
// Port-level assertions for the classifier core, with the bind that attaches them.
module rapc_checker #(
    parameter int COUNT_WIDTH = rapc_pkg::CountWidthDefault
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input rapc_pkg::t_out_word i_out_data
);
    import rapc_pkg::*;

    localparam bit Truncated = (COUNT_WIDTH > TotalWidth);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // no result right after reset is released
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result present straight out of reset");

    // every read class total stays within the read total
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (Truncated ||
            ((i_out_data.hits_total <= i_out_data.reads_total) &&
             (i_out_data.strided_total <= i_out_data.reads_total) &&
             (i_out_data.chasing_total <= i_out_data.reads_total) &&
             (i_out_data.random_total <= i_out_data.reads_total))))
        else $error("class total exceeds read total");

    // the total of the reported class has been counted
    a_class_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (Truncated ||
            ((i_out_data.access_class == ACC_WRITE)   && (i_out_data.writes_total  != '0)) ||
            ((i_out_data.access_class == ACC_HIT)     && (i_out_data.hits_total    != '0)) ||
            ((i_out_data.access_class == ACC_STRIDED) && (i_out_data.strided_total != '0)) ||
            ((i_out_data.access_class == ACC_CHASING) && (i_out_data.chasing_total != '0)) ||
            ((i_out_data.access_class == ACC_RANDOM)  && (i_out_data.random_total  != '0))))
        else $error("reported class has a zero total");
endmodule

bind read_access_pattern_classifier_core rapc_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_rapc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* sim/tb_read_access_pattern_classifier_core.sv */
// Testbench for the read access pattern classifier core: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb_read_access_pattern_classifier_core;
    import rapc_pkg::*;

    // Run the core with a 16-bit counter width, narrower than the 48-bit totals.
    localparam int LineOffsetBits = LineOffsetBitsDefault;
    localparam int CountWidth     = 16;
    localparam int ResetCycles    = 12;
    localparam int RandomItems    = 1600;
    localparam int HoldCycles     = 400;
    localparam int WatchdogLimit  = 4000;
    localparam int DrainCycles    = 16;
    localparam int NumDirected    = 15;

    localparam logic [63:0] LineMask   = ~((64'd1 << LineOffsetBits) - 64'd1);
    localparam logic [63:0] OffsetMask = (64'd1 << LineOffsetBits) - 64'd1;
    localparam logic [63:0] CountMax   = (CountWidth >= 64) ? '1
                                         : ((64'd1 << CountWidth) - 64'd1);

    // Shapes of generated accesses, each aimed at one class given the current history.
    typedef enum {
        KIND_WRITE,
        KIND_HIT,
        KIND_STRIDE,
        KIND_RELEARN,
        KIND_CHASE,
        KIND_NEAR,
        KIND_RANDOM,
        KIND_NOISE
    } t_access_kind;

    // One directed row: the access, and a typed-in result where it is obvious.
    typedef struct packed {
        logic          mode;
        logic [63:0]   address;
        logic          llc_hit;
        logic [63:0]   loaded_value;
        logic          pinned;
        t_access_class cls;
        logic [47:0]   reads;
        logic [47:0]   writes;
        logic [47:0]   hits;
        logic [47:0]   strided;
        logic [47:0]   chasing;
        logic [47:0]   randoms;
    } t_dir_row;

    typedef struct packed {
        logic      has;
        t_out_word res;
    } t_pin;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rapc_stream_if #(.T(t_in_word))  in_if  ();
    rapc_stream_if #(.T(t_out_word)) out_if ();

    read_access_pattern_classifier_core #(
        .LINE_OFFSET_BITS(LineOffsetBits),
        .COUNT_WIDTH     (CountWidth)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 clk = ~clk;

    // Directed rows. Typed results follow the history from reset:
    // a write, a hit, the first miss on line zero (strided against the zero history),
    // and a read of the top address after a relearned stride.
    t_dir_row directed_rows [NumDirected] = '{
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, ACC_WRITE, 48'd0, 48'd1, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h0, 1'b1, 64'h0,
          1'b1, ACC_HIT, 48'd1, 48'd1, 48'd1, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h3F, 1'b0, 64'h1000,
          1'b1, ACC_STRIDED, 48'd2, 48'd1, 48'd1, 48'd1, 48'd0, 48'd0},
        '{1'b0, 64'h1000, 1'b0, 64'hFFFF_FFFF_FFFF_FFC0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h2005, 1'b0, 64'h0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0,
          1'b1, ACC_RANDOM, 48'd5, 48'd1, 48'd1, 48'd2, 48'd1, 48'd1},
        '{1'b0, 64'h0, 1'b0, 64'h80,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h40, 1'b0, 64'h123,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h0, 1'b0, 64'h0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b1, 64'h0, 1'b0, 64'h0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 64'h5555_5555_5555_5555,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
        '{1'b0, 64'h8000_0000_0000_0000, 1'b0, 64'h0,
          1'b0, ACC_WRITE, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0}
    };

    // Predictor history and counters, updated once per accepted input word.
    logic [63:0] pred_line   = '0;
    logic [63:0] pred_stride = '0;
    logic [63:0] pred_word   = '0;
    logic [63:0] n_reads     = '0;
    logic [63:0] n_writes    = '0;
    logic [63:0] n_hits      = '0;
    logic [63:0] n_strided   = '0;
    logic [63:0] n_chasing   = '0;
    logic [63:0] n_random    = '0;

    t_out_word expected_q [$];
    t_pin      pinned_q   [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int gap_pct     = 30;
    bit hold_req    = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] bump(input logic [63:0] c);
        return (c >= CountMax) ? CountMax : c + 64'd1;
    endfunction

    // Classify one access against the predictor history and advance it.
    function automatic t_out_word classify_access(input t_in_word w);
        t_out_word   r;
        logic [63:0] line;
        if (w.mode) begin
            n_writes       = bump(n_writes);
            r.access_class = ACC_WRITE;
        end else begin
            n_reads = bump(n_reads);
            if (w.llc_hit) begin
                n_hits         = bump(n_hits);
                r.access_class = ACC_HIT;
            end else begin
                line = w.address & LineMask;
                if (pred_line + pred_stride == line) begin
                    n_strided      = bump(n_strided);
                    r.access_class = ACC_STRIDED;
                end else begin
                    // relearn the stride from the last miss line
                    pred_stride = line - pred_line;
                    if (w.address == pred_word) begin
                        n_chasing      = bump(n_chasing);
                        r.access_class = ACC_CHASING;
                    end else begin
                        n_random       = bump(n_random);
                        r.access_class = ACC_RANDOM;
                    end
                end
                pred_word = w.loaded_value;
                pred_line = line;
            end
        end
        r.reads_total   = n_reads[TotalWidth-1:0];
        r.writes_total  = n_writes[TotalWidth-1:0];
        r.hits_total    = n_hits[TotalWidth-1:0];
        r.strided_total = n_strided[TotalWidth-1:0];
        r.chasing_total = n_chasing[TotalWidth-1:0];
        r.random_total  = n_random[TotalWidth-1:0];
        return r;
    endfunction

    // Build an access of the given shape from the predictor history as it stands right now.
    function automatic t_in_word make_access(input t_access_kind k);
        t_in_word    w;
        logic [63:0] delta;
        longint      step;
        w.mode         = 1'b0;
        w.llc_hit      = 1'b0;
        w.address      = rand64();
        w.loaded_value = rand64();
        case (k)
            KIND_WRITE: begin
                w.mode    = 1'b1;
                w.llc_hit = 1'($urandom_range(0, 1));
            end
            KIND_HIT: w.llc_hit = 1'b1;
            KIND_STRIDE: w.address = (pred_line + pred_stride) | (rand64() & OffsetMask);
            KIND_RELEARN: begin
                // mostly a short signed hop in lines, now and then a far one
                step  = longint'($urandom_range(0, 32)) - 16;
                delta = step << LineOffsetBits;
                if ($urandom_range(0, 7) == 0) begin
                    delta = rand64() & LineMask;
                end
                w.address = (pred_line + delta) | (rand64() & OffsetMask);
            end
            KIND_CHASE: w.address = pred_word;
            KIND_NEAR: w.address = pred_word ^ (64'd1 << $urandom_range(0, 63));
            KIND_NOISE: begin
                w.mode    = 1'($urandom_range(0, 1));
                w.llc_hit = 1'($urandom_range(0, 1));
            end
            default: begin
                case ($urandom_range(0, 7))
                    0:       w.address = '0;
                    1:       w.address = '1;
                    default: w.address = rand64();
                endcase
            end
        endcase
        return w;
    endfunction

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got 0x%h, want 0x%h", $time, field, got, want);
    endtask

    // Offer one word from a falling edge and hold it until it is taken.
    // Bursts of random length are separated, now and then, by random gaps.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge clk); while (!in_if.ready);
        @(negedge clk);
    endtask

    task automatic issue(input t_access_kind k);
        send_word(make_access(k));
        items_sent++;
    endtask

    // Sample both handshakes at the rising edge: predict on input, check on output,
    // and watch for a stretch with no progress at all.
    always @(posedge clk) begin : scoreboard
        t_out_word want;
        t_out_word got;
        t_pin      pin;
        bit        moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready) begin
                moved = 1'b1;
                want  = classify_access(in_if.data);
                if (pinned_q.size() > 0) begin
                    pin = pinned_q.pop_front();
                    if (pin.has) begin
                        want = pin.res;
                    end
                end
                expected_q = {expected_q, want};
            end
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                got   = out_if.data;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result word", 64'(got.access_class), '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.access_class !== want.access_class)
                        report_mismatch("access_class", 64'(got.access_class),
                                        64'(want.access_class));
                    if (got.reads_total !== want.reads_total)
                        report_mismatch("reads_total", 64'(got.reads_total),
                                        64'(want.reads_total));
                    if (got.writes_total !== want.writes_total)
                        report_mismatch("writes_total", 64'(got.writes_total),
                                        64'(want.writes_total));
                    if (got.hits_total !== want.hits_total)
                        report_mismatch("hits_total", 64'(got.hits_total),
                                        64'(want.hits_total));
                    if (got.strided_total !== want.strided_total)
                        report_mismatch("strided_total", 64'(got.strided_total),
                                        64'(want.strided_total));
                    if (got.chasing_total !== want.chasing_total)
                        report_mismatch("chasing_total", 64'(got.chasing_total),
                                        64'(want.chasing_total));
                    if (got.random_total !== want.random_total)
                        report_mismatch("random_total", 64'(got.random_total),
                                        64'(want.random_total));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: segments of random length, each with its own ready rate.
    // On request, hold ready low for a long counted stretch so the core backs up.
    initial begin : result_sink
        int seg_len;
        int ready_pct;
        out_if.ready = 1'b0;
        forever begin
            seg_len = $urandom_range(1, 64);
            case ($urandom_range(0, 4))
                0, 1:    ready_pct = 100;
                2:       ready_pct = 85;
                3:       ready_pct = 50;
                default: ready_pct = 20;
            endcase
            repeat (seg_len) begin
                @(negedge clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_if.ready <= 1'b0;
                    repeat (HoldCycles - 1) begin
                        @(negedge clk);
                        out_if.ready <= 1'b0;
                    end
                end else begin
                    out_if.ready <= ($urandom_range(0, 99) < ready_pct);
                end
            end
        end
    end

    initial begin : stimulus
        t_in_word w;
        t_pin     pin;
        int       next_hold;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        rst_n       = 1'b0;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows, in order, each pinned or left to the predictor.
        foreach (directed_rows[i]) begin
            w.mode                = directed_rows[i].mode;
            w.address             = directed_rows[i].address;
            w.llc_hit             = directed_rows[i].llc_hit;
            w.loaded_value        = directed_rows[i].loaded_value;
            pin.has               = directed_rows[i].pinned;
            pin.res.access_class  = directed_rows[i].cls;
            pin.res.reads_total   = directed_rows[i].reads;
            pin.res.writes_total  = directed_rows[i].writes;
            pin.res.hits_total    = directed_rows[i].hits;
            pin.res.strided_total = directed_rows[i].strided;
            pin.res.chasing_total = directed_rows[i].chasing;
            pin.res.random_total  = directed_rows[i].randoms;
            pinned_q = {pinned_q, pin};
            send_word(w);
        end

        // Random traffic: mostly well-formed strided runs and pointer chains,
        // the rest hits, writes, random accesses, near misses and noise.
        next_hold = 400;
        while (items_sent < RandomItems) begin
            if (items_sent >= next_hold) begin
                hold_req  = 1'b1;
                next_hold = next_hold + 700;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    issue(KIND_RELEARN);
                    repeat ($urandom_range(1, 8)) issue(KIND_STRIDE);
                end
                3, 4: repeat ($urandom_range(2, 8)) issue(KIND_CHASE);
                5: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 1) == 1) issue(KIND_HIT);
                        else issue(KIND_WRITE);
                    end
                end
                6: repeat ($urandom_range(1, 4)) issue(KIND_RANDOM);
                7: repeat ($urandom_range(1, 4)) issue(KIND_NOISE);
                8: begin
                    // stride run broken up by words that must not touch the history
                    repeat ($urandom_range(2, 6)) begin
                        issue(KIND_STRIDE);
                        if ($urandom_range(0, 1) == 1) issue(KIND_HIT);
                        else issue(KIND_WRITE);
                    end
                end
                default: repeat ($urandom_range(1, 3)) issue(KIND_NEAR);
            endcase
        end
        in_if.valid <= 1'b0;

        // Drain: the watchdog ends the run if a result never shows up.
        while (expected_q.size() > 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
